// ===== hw/rtl/clipped_color_key_blitter_core_macros.svh =====
// assertion macros for the blitter core checker
// no dependencies
`ifndef CLIPPED_COLOR_KEY_BLITTER_CORE_MACROS_SVH
`define CLIPPED_COLOR_KEY_BLITTER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define CCKB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cckb check failed");

// next-cycle implication, off during reset
`define CCKB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cckb check failed");

// next-cycle implication, always checked
`define CCKB_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("cckb check failed");

`endif

// ===== hw/rtl/cckb_pkg.sv =====
// shared types, codes and clip arithmetic for the blitter core
// no dependencies
package cckb_pkg;

    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_LEFT   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_TOP    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_RIGHT  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_BOTTOM = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEST_PITCH  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEST_BASE   = 3'd5;

    localparam logic OP_START = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef struct packed {
        logic [10:0] clip_left;
        logic [10:0] clip_top;
        logic [10:0] clip_right;
        logic [10:0] clip_bottom;
        logic [12:0] dest_pitch;
        logic [23:0] dest_base;
    } t_cfg;

    typedef struct packed {
        logic        ok;
        logic [10:0] dstart;
        logic [11:0] sstart;
        logic [10:0] run;
    } t_axis;

    // one classified beat between front and back
    typedef struct packed {
        logic        is_start;
        logic        ok;
        logic        use_key;
        logic [7:0]  pixel;
        logic [11:0] src_x;
        logic [11:0] src_y;
        logic [10:0] run_w;
        logic [10:0] run_h;
        logic [10:0] dl;
        logic [23:0] product;
    } t_cmd;

    typedef struct packed {
        logic        is_status;
        logic        status;
        logic [11:0] clipped_src_x;
        logic [11:0] clipped_src_y;
        logic [10:0] run_width;
        logic [10:0] run_height;
        logic        write_enable;
        logic [23:0] write_address;
        logic [7:0]  write_pixel;
        logic        last_pixel;
    } t_res;

    function automatic t_axis clip_axis(
        input logic signed [11:0] d,
        input logic        [10:0] s,
        input logic        [10:0] len,
        input logic        [10:0] lo,
        input logic        [10:0] hi
    );
        t_axis              res;
        logic signed [14:0] dv;
        logic signed [14:0] sv;
        logic signed [14:0] lv;
        logic signed [14:0] lov;
        logic signed [14:0] hiv;
        logic signed [14:0] sl;
        logic signed [14:0] sr;
        logic signed [14:0] rn;
        logic               left_cut;
        logic               right_cut;
        dv  = {{3{d[11]}}, d};
        sv  = {4'b0, s};
        lv  = {4'b0, len};
        lov = {4'b0, lo};
        hiv = {4'b0, hi};
        left_cut  = dv < lov;
        right_cut = dv > (hiv - lv);
        sl = left_cut ? (sv + lov - dv) : sv;
        sr = right_cut ? (sv + hiv - dv) : (sv + lv);
        rn = sr - sl;
        res.ok     = !(dv <= (lov - lv)) && !(dv >= hiv);
        res.dstart = left_cut ? lo : d[10:0];
        res.sstart = sl[11:0];
        res.run    = (rn < 0) ? 11'd0 : rn[10:0];
        return res;
    endfunction

endpackage

// ===== hw/rtl/cckb_front.sv =====
// front: accepts input beats, clips start commands, forms the row product
// depends on cckb_pkg
module cckb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cckb_pkg::t_cfg      i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_opcode,
    input  logic signed [11:0]  i_dest_x,
    input  logic signed [11:0]  i_dest_y,
    input  logic [10:0]         i_src_x,
    input  logic [10:0]         i_src_y,
    input  logic [10:0]         i_rect_width,
    input  logic [10:0]         i_rect_height,
    input  logic                i_use_key,
    input  logic [7:0]          i_pixel,
    input  logic                i_q_full,
    output logic                o_q_push,
    output cckb_pkg::t_cmd      o_q_data
);

    logic           r_valid;
    logic           r_is_start;
    logic           r_ok;
    logic           r_use_key;
    logic [7:0]     r_pixel;
    logic [11:0]    r_src_x;
    logic [11:0]    r_src_y;
    logic [10:0]    r_run_w;
    logic [10:0]    r_run_h;
    logic [10:0]    r_dl;
    logic [10:0]    r_dt;
    logic           n_valid;
    logic           load;
    cckb_pkg::t_axis ax;
    cckb_pkg::t_axis ay;

    assign ax = cckb_pkg::clip_axis(i_dest_x, i_src_x, i_rect_width,
                                    i_cfg.clip_left, i_cfg.clip_right);
    assign ay = cckb_pkg::clip_axis(i_dest_y, i_src_y, i_rect_height,
                                    i_cfg.clip_top, i_cfg.clip_bottom);

    assign o_in_stall = r_valid && i_q_full;
    assign load       = i_in_valid && !o_in_stall;
    assign o_q_push   = r_valid && !i_q_full;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_is_start <= (i_opcode == cckb_pkg::OP_START);
            r_ok       <= ax.ok && ay.ok;
            r_use_key  <= i_use_key;
            r_pixel    <= i_pixel;
            r_src_x    <= ax.sstart;
            r_src_y    <= ay.sstart;
            r_run_w    <= ax.run;
            r_run_h    <= ay.run;
            r_dl       <= ax.dstart;
            r_dt       <= ay.dstart;
        end
    end

    // row offset: clipped top row times pitch
    always_comb begin
        o_q_data.is_start = r_is_start;
        o_q_data.ok       = r_ok;
        o_q_data.use_key  = r_use_key;
        o_q_data.pixel    = r_pixel;
        o_q_data.src_x    = r_src_x;
        o_q_data.src_y    = r_src_y;
        o_q_data.run_w    = r_run_w;
        o_q_data.run_h    = r_run_h;
        o_q_data.dl       = r_dl;
        o_q_data.product  = 24'(r_dt) * 24'(i_cfg.dest_pitch);
    end

endmodule

// ===== hw/rtl/cckb_queue.sv =====
// short queue of classified beats between front and back
// depends on cckb_pkg
module cckb_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cckb_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output cckb_pkg::t_cmd o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cckb_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic [PW-1:0]  n_wr;
    logic [PW-1:0]  n_rd;
    logic [CW-1:0]  n_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/cckb_back.sv =====
// back: blit state, address stepping and the output register
// depends on cckb_pkg
module cckb_back #(
    parameter int ADDRESS_BITS = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cckb_pkg::t_cfg i_cfg,
    input  logic           i_q_empty,
    input  cckb_pkg::t_cmd i_q_data,
    output logic           o_q_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output cckb_pkg::t_res o_res
);

    localparam int AW = ADDRESS_BITS;

    logic           r_active;
    logic           r_key;
    logic [10:0]    r_col;
    logic [10:0]    r_row;
    logic [10:0]    r_win_w;
    logic [10:0]    r_win_h;
    logic [AW-1:0]  r_row_addr;
    logic [AW-1:0]  r_pix_addr;
    logic           r_out_valid;
    cckb_pkg::t_res r_res;

    logic           n_active;
    logic           n_key;
    logic [10:0]    n_col;
    logic [10:0]    n_row;
    logic [10:0]    n_win_w;
    logic [10:0]    n_win_h;
    logic [AW-1:0]  n_row_addr;
    logic [AW-1:0]  n_pix_addr;
    logic           n_out_valid;
    cckb_pkg::t_res n_res;

    logic [AW-1:0]  start_addr;
    logic [11:0]    col_inc;
    logic [11:0]    row_inc;
    logic           row_end;
    logic           last;
    cckb_pkg::t_cmd cmd;

    assign cmd         = i_q_data;
    assign o_q_pop     = !i_q_empty && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    assign start_addr = AW'(i_cfg.dest_base) + AW'(cmd.product) + AW'(cmd.dl);
    assign col_inc    = {1'b0, r_col} + 12'd1;
    assign row_inc    = {1'b0, r_row} + 12'd1;
    assign row_end    = col_inc >= {1'b0, r_win_w};
    assign last       = (row_inc == {1'b0, r_win_h}) && (col_inc == {1'b0, r_win_w});

    always_comb begin
        n_active    = r_active;
        n_key       = r_key;
        n_col       = r_col;
        n_row       = r_row;
        n_win_w     = r_win_w;
        n_win_h     = r_win_h;
        n_row_addr  = r_row_addr;
        n_pix_addr  = r_pix_addr;
        n_out_valid = r_out_valid && i_out_stall;
        n_res       = r_res;
        if (o_q_pop) begin
            n_out_valid = 1'b1;
            n_res       = '0;
            if (cmd.is_start) begin
                n_res.is_status = 1'b1;
                n_key           = cmd.use_key;
                n_col           = '0;
                n_row           = '0;
                n_active        = 1'b0;
                n_win_w         = '0;
                n_win_h         = '0;
                if (cmd.ok) begin
                    n_res.status        = 1'b1;
                    n_res.clipped_src_x = cmd.src_x;
                    n_res.clipped_src_y = cmd.src_y;
                    n_res.run_width     = cmd.run_w;
                    n_res.run_height    = cmd.run_h;
                    n_win_w             = cmd.run_w;
                    n_win_h             = cmd.run_h;
                    n_row_addr          = start_addr;
                    n_pix_addr          = start_addr;
                    n_active            = (cmd.run_w != '0) && (cmd.run_h != '0);
                end
            end else if (r_active) begin
                n_res.write_enable  = !(r_key && (cmd.pixel == 8'd0));
                n_res.write_address = 24'(r_pix_addr);
                n_res.write_pixel   = cmd.pixel;
                n_res.last_pixel    = last;
                n_col               = col_inc[10:0];
                n_pix_addr          = r_pix_addr + 1'b1;
                if (row_end) begin
                    n_col      = '0;
                    n_row      = row_inc[10:0];
                    n_row_addr = r_row_addr + AW'(i_cfg.dest_pitch);
                    n_pix_addr = r_row_addr + AW'(i_cfg.dest_pitch);
                end
                if (last) begin
                    n_active = 1'b0;
                    n_col    = '0;
                    n_row    = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_key       <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_key       <= n_key;
            r_col       <= n_col;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win_w    <= n_win_w;
        r_win_h    <= n_win_h;
        r_row_addr <= n_row_addr;
        r_pix_addr <= n_pix_addr;
        r_res      <= n_res;
    end

endmodule

// ===== hw/rtl/clipped_color_key_blitter_core.sv =====
// top level of the clipped color-key blitter: config registers, front, queue, back
// depends on cckb_pkg, cckb_front, cckb_queue, cckb_back
//
//   channel   direction  handshake               beat
//   in        input      i_in_valid / o_in_stall  start command or one source pixel
//   out       output     o_out_valid / i_out_stall status or one pixel write
//   cfg       input      i_cfg_valid / o_cfg_ready register index and data
//
// one beat per cycle sustained while the output is not stalled; a result passes through the front
// register, a queue slot and the output register, and waits longer while the queue holds earlier beats
// the front and back each stall on their own: the queue of QUEUE_DEPTH beats absorbs
// output stalls, and the input stalls only when the front register waits on a full queue
// reset restores the clip window 0..320 x 0..240, pitch 320, base 0, and an idle blit
module clipped_color_key_blitter_core #(
    parameter int ADDRESS_BITS = 24,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_opcode,
    input  logic signed [11:0]  i_dest_x,
    input  logic signed [11:0]  i_dest_y,
    input  logic [10:0]         i_src_x,
    input  logic [10:0]         i_src_y,
    input  logic [10:0]         i_rect_width,
    input  logic [10:0]         i_rect_height,
    input  logic                i_use_key,
    input  logic [7:0]          i_pixel,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_is_status,
    output logic                o_status,
    output logic [11:0]         o_clipped_src_x,
    output logic [11:0]         o_clipped_src_y,
    output logic [10:0]         o_run_width,
    output logic [10:0]         o_run_height,
    output logic                o_write_enable,
    output logic [23:0]         o_write_address,
    output logic [7:0]          o_write_pixel,
    output logic                o_last_pixel
);

    cckb_pkg::t_cfg r_cfg;
    cckb_pkg::t_cmd q_in;
    cckb_pkg::t_cmd q_out;
    cckb_pkg::t_res res;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    logic           cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_left   <= 11'd0;
            r_cfg.clip_top    <= 11'd0;
            r_cfg.clip_right  <= 11'd320;
            r_cfg.clip_bottom <= 11'd240;
            r_cfg.dest_pitch  <= 13'd320;
            r_cfg.dest_base   <= 24'd0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                cckb_pkg::CFG_CLIP_LEFT:   r_cfg.clip_left   <= i_cfg_data[10:0];
                cckb_pkg::CFG_CLIP_TOP:    r_cfg.clip_top    <= i_cfg_data[10:0];
                cckb_pkg::CFG_CLIP_RIGHT:  r_cfg.clip_right  <= i_cfg_data[10:0];
                cckb_pkg::CFG_CLIP_BOTTOM: r_cfg.clip_bottom <= i_cfg_data[10:0];
                cckb_pkg::CFG_DEST_PITCH:  r_cfg.dest_pitch  <= i_cfg_data[12:0];
                cckb_pkg::CFG_DEST_BASE:   r_cfg.dest_base   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cckb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_dest_x      (i_dest_x),
        .i_dest_y      (i_dest_y),
        .i_src_x       (i_src_x),
        .i_src_y       (i_src_y),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_use_key     (i_use_key),
        .i_pixel       (i_pixel),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_in)
    );

    cckb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    cckb_back #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .i_q_data    (q_out),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res)
    );

    assign o_is_status     = res.is_status;
    assign o_status        = res.status;
    assign o_clipped_src_x = res.clipped_src_x;
    assign o_clipped_src_y = res.clipped_src_y;
    assign o_run_width     = res.run_width;
    assign o_run_height    = res.run_height;
    assign o_write_enable  = res.write_enable;
    assign o_write_address = res.write_address;
    assign o_write_pixel   = res.write_pixel;
    assign o_last_pixel    = res.last_pixel;

endmodule

// ===== hw/rtl/cckb_checker.sv =====
// port-level checks for the blitter core, attached by bind
// depends on clipped_color_key_blitter_core_macros.svh
`include "clipped_color_key_blitter_core_macros.svh"

module cckb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_is_status,
    input logic               o_status,
    input logic [11:0]        o_clipped_src_x,
    input logic [11:0]        o_clipped_src_y,
    input logic [10:0]        o_run_width,
    input logic [10:0]        o_run_height,
    input logic               o_write_enable,
    input logic [23:0]        o_write_address,
    input logic [7:0]         o_write_pixel,
    input logic               o_last_pixel
);

    logic [81:0] out_word;
    logic        out_held;
    logic        pix_zero;
    logic        win_zero;

    assign out_word = {o_is_status, o_status, o_clipped_src_x, o_clipped_src_y, o_run_width,
                       o_run_height, o_write_enable, o_write_address, o_write_pixel,
                       o_last_pixel};
    assign out_held = o_out_valid && i_out_stall;
    assign pix_zero = !o_write_enable && !o_last_pixel && (o_write_address == 24'd0) &&
                      (o_write_pixel == 8'd0);
    assign win_zero = (o_clipped_src_x == 12'd0) && (o_clipped_src_y == 12'd0) &&
                      (o_run_width == 11'd0) && (o_run_height == 11'd0);

    // no output beat right after reset
    `CCKB_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_out_valid)

    // stalled output beat holds
    `CCKB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(out_word))

    // status beat carries no pixel write
    `CCKB_ASSERT_NOW(a_status_clean, i_clk, i_rst_n, o_out_valid && o_is_status, pix_zero)

    // pixel beat and rejected start carry no clip window
    `CCKB_ASSERT_NOW(a_no_window, i_clk, i_rst_n, o_out_valid && !o_status, win_zero)

endmodule

bind clipped_color_key_blitter_core cckb_checker u_cckb_checker (.*);

// ===== sim/testbench.sv =====
// self-checking testbench for clipped_color_key_blitter_core: directed blits, then random blit traffic
// depends on cckb_pkg and the core rtl; predicts every result beat and compares field by field
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic               opcode;
        logic signed [11:0] dest_x;
        logic signed [11:0] dest_y;
        logic [10:0]        src_x;
        logic [10:0]        src_y;
        logic [10:0]        rect_w;
        logic [10:0]        rect_h;
        logic               use_key;
        logic [7:0]         pixel;
    } t_beat;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [23:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_opcode;
    logic signed [11:0] i_dest_x;
    logic signed [11:0] i_dest_y;
    logic [10:0]        i_src_x;
    logic [10:0]        i_src_y;
    logic [10:0]        i_rect_width;
    logic [10:0]        i_rect_height;
    logic               i_use_key;
    logic [7:0]         i_pixel;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_is_status;
    logic               o_status;
    logic [11:0]        o_clipped_src_x;
    logic [11:0]        o_clipped_src_y;
    logic [10:0]        o_run_width;
    logic [10:0]        o_run_height;
    logic               o_write_enable;
    logic [23:0]        o_write_address;
    logic [7:0]         o_write_pixel;
    logic               o_last_pixel;

    // register shadow, fields in package order: left, top, right, bottom, pitch, base
    cckb_pkg::t_cfg regs_now = '{11'd0, 11'd0, 11'd320, 11'd240, 13'd320, 24'd0};
    logic        blit_on  = 1'b0;
    logic        key_on   = 1'b0;
    logic [10:0] col_idx  = '0;
    logic [10:0] row_idx  = '0;
    logic [10:0] win_w    = '0;
    logic [10:0] win_h    = '0;
    logic [23:0] row_addr = '0;
    logic [23:0] pix_addr = '0;

    cckb_pkg::t_res answers_due[$];
    cckb_pkg::t_res latest_answer;
    cckb_pkg::t_res due_beat;
    int   mismatches = 0;
    int   beats_sent = 0;
    int   out_hold;
    bit   idle_off = 1'b0;

    clipped_color_key_blitter_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_dest_x        (i_dest_x),
        .i_dest_y        (i_dest_y),
        .i_src_x         (i_src_x),
        .i_src_y         (i_src_y),
        .i_rect_width    (i_rect_width),
        .i_rect_height   (i_rect_height),
        .i_use_key       (i_use_key),
        .i_pixel         (i_pixel),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_is_status     (o_is_status),
        .o_status        (o_status),
        .o_clipped_src_x (o_clipped_src_x),
        .o_clipped_src_y (o_clipped_src_y),
        .o_run_width     (o_run_width),
        .o_run_height    (o_run_height),
        .o_write_enable  (o_write_enable),
        .o_write_address (o_write_address),
        .o_write_pixel   (o_write_pixel),
        .o_last_pixel    (o_last_pixel)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int pick_wait();
        if (idle_off || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // one axis of the clip: false when the span misses the window entirely
    function automatic bit clip_span(input int d, input int s, input int len, input int lo,
                                     input int hi, output int d_start, output int s_start,
                                     output int run);
        int s_end;
        d_start = d;
        s_start = s;
        s_end   = s + len;
        run     = 0;
        if (d <= lo - len) begin
            return 1'b0;
        end
        if (d < lo) begin
            d_start = lo;
            s_start = s + (lo - d);
        end
        if (d >= hi) begin
            return 1'b0;
        end
        if (d > hi - len) begin
            s_end = hi - d + s;
        end
        run = s_end - s_start;
        return 1'b1;
    endfunction

    function automatic cckb_pkg::t_res predict_answer(input t_beat b);
        cckb_pkg::t_res r;
        int   d_l, s_l, run_x, d_t, s_t, run_y;
        bit   hit_x, hit_y, at_end;
        r = '0;
        if (b.opcode == cckb_pkg::OP_START) begin
            r.is_status = 1'b1;
            blit_on = 1'b0;
            key_on  = b.use_key;
            col_idx = '0;
            row_idx = '0;
            hit_x = clip_span(int'(b.dest_x), int'(b.src_x), int'(b.rect_w),
                              int'(regs_now.clip_left), int'(regs_now.clip_right),
                              d_l, s_l, run_x);
            hit_y = clip_span(int'(b.dest_y), int'(b.src_y), int'(b.rect_h),
                              int'(regs_now.clip_top), int'(regs_now.clip_bottom),
                              d_t, s_t, run_y);
            if (!(hit_x && hit_y)) begin
                win_w = '0;
                win_h = '0;
                return r;
            end
            if (run_x < 0) run_x = 0;
            if (run_y < 0) run_y = 0;
            r.status        = 1'b1;
            r.clipped_src_x = 12'(s_l);
            r.clipped_src_y = 12'(s_t);
            r.run_width     = 11'(run_x);
            r.run_height    = 11'(run_y);
            win_w = 11'(run_x);
            win_h = 11'(run_y);
            row_addr = 24'(longint'(regs_now.dest_base) +
                           longint'(d_t) * longint'(regs_now.dest_pitch) + longint'(d_l));
            pix_addr = row_addr;
            blit_on  = (win_w != 0) && (win_h != 0);
            return r;
        end
        if (!blit_on) begin
            return r;
        end
        at_end = (int'(row_idx) + 1 == int'(win_h)) && (int'(col_idx) + 1 == int'(win_w));
        r.write_enable  = !(key_on && b.pixel == 8'h00);
        r.write_address = pix_addr;
        r.write_pixel   = b.pixel;
        r.last_pixel    = at_end;
        col_idx  = col_idx + 11'd1;
        pix_addr = pix_addr + 24'd1;
        if (col_idx >= win_w) begin
            col_idx  = '0;
            row_idx  = row_idx + 11'd1;
            row_addr = row_addr + 24'(regs_now.dest_pitch);
            pix_addr = row_addr;
        end
        if (at_end) begin
            blit_on = 1'b0;
            col_idx = '0;
            row_idx = '0;
        end
        return r;
    endfunction

    function automatic t_beat mk_start(input int dx, input int dy, input int sx, input int sy,
                                       input int w, input int h, input bit key);
        t_beat b;
        b.opcode  = cckb_pkg::OP_START;
        b.dest_x  = 12'(dx);
        b.dest_y  = 12'(dy);
        b.src_x   = 11'(sx);
        b.src_y   = 11'(sy);
        b.rect_w  = 11'(w);
        b.rect_h  = 11'(h);
        b.use_key = key;
        b.pixel   = 8'($urandom);
        return b;
    endfunction

    // start-only fields carry junk on pixel beats
    function automatic t_beat mk_pixel(input logic [7:0] value);
        t_beat b;
        b = t_beat'($bits(t_beat)'({$urandom, $urandom, $urandom}));
        b.opcode = cckb_pkg::OP_PIXEL;
        b.pixel  = value;
        return b;
    endfunction

    function automatic logic [7:0] rand_pixel();
        return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
    endfunction

    function automatic t_beat make_start();
        t_beat       b;
        logic [10:0] edge_col;
        logic [10:0] edge_row;
        b = mk_start(0, 0, $urandom, $urandom, $urandom_range(0, 10), $urandom_range(0, 10),
                     1'($urandom_range(0, 1)));
        if ($urandom_range(0, 9) == 0) b.rect_w = 11'($urandom);
        if ($urandom_range(0, 9) == 0) b.rect_h = 11'($urandom);
        edge_col = $urandom_range(0, 1) ? regs_now.clip_left : regs_now.clip_right;
        edge_row = $urandom_range(0, 1) ? regs_now.clip_top : regs_now.clip_bottom;
        b.dest_x = 12'(int'(edge_col) + int'($urandom_range(0, 24)) - 16);
        b.dest_y = 12'(int'(edge_row) + int'($urandom_range(0, 24)) - 16);
        if ($urandom_range(0, 4) == 0) b.dest_x = 12'($urandom);
        if ($urandom_range(0, 4) == 0) b.dest_y = 12'($urandom);
        return b;
    endfunction

    function automatic cckb_pkg::t_cfg pick_regs(input int phase);
        cckb_pkg::t_cfg c;
        c.clip_left   = 11'($urandom_range(0, 2000));
        c.clip_top    = 11'($urandom_range(0, 2000));
        c.clip_right  = 11'(int'(c.clip_left) + $urandom_range(0, 40));
        c.clip_bottom = 11'(int'(c.clip_top) + $urandom_range(0, 40));
        c.dest_pitch  = 13'($urandom_range(1, 4096));
        c.dest_base   = 24'($urandom);
        case (phase)
            0: c = '{11'd0, 11'd0, 11'd2047, 11'd2047, 13'd4096, 24'hFFFFFF};
            1: c = '{11'd2047, 11'd2047, 11'd2047, 11'd2047, 13'd1, 24'd0};
            2: begin
                c.clip_left   = 11'($urandom_range(100, 2047));
                c.clip_top    = 11'($urandom_range(100, 2047));
                c.clip_right  = c.clip_left - 11'($urandom_range(1, 50));
                c.clip_bottom = c.clip_top - 11'($urandom_range(1, 50));
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatches < 10) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (got !== want) begin
            flag_mismatch($sformatf("%s expected %0h actual %0h", name, want, got));
        end
    endtask

    task automatic send_beat(input t_beat b);
        int gap;
        gap = pick_wait();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_opcode      = b.opcode;
        i_dest_x      = b.dest_x;
        i_dest_y      = b.dest_y;
        i_src_x       = b.src_x;
        i_src_y       = b.src_y;
        i_rect_width  = b.rect_w;
        i_rect_height = b.rect_h;
        i_use_key     = b.use_key;
        i_pixel       = b.pixel;
        i_in_valid    = 1'b1;
        latest_answer = predict_answer(b);
        answers_due.push_back(latest_answer);
        beats_sent++;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic settle();
        int spins;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        spins = 0;
        while (answers_due.size() != 0 && spins < 4000) begin
            @(posedge i_clk);
            spins++;
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            cckb_pkg::CFG_CLIP_LEFT:   regs_now.clip_left   = val[10:0];
            cckb_pkg::CFG_CLIP_TOP:    regs_now.clip_top    = val[10:0];
            cckb_pkg::CFG_CLIP_RIGHT:  regs_now.clip_right  = val[10:0];
            cckb_pkg::CFG_CLIP_BOTTOM: regs_now.clip_bottom = val[10:0];
            cckb_pkg::CFG_DEST_PITCH:  regs_now.dest_pitch  = val[12:0];
            cckb_pkg::CFG_DEST_BASE:   regs_now.dest_base   = val[23:0];
            default: ;
        endcase
    endtask

    task automatic load_regs(input cckb_pkg::t_cfg c);
        settle();
        write_reg(cckb_pkg::CFG_CLIP_LEFT, 24'(c.clip_left));
        write_reg(cckb_pkg::CFG_CLIP_TOP, 24'(c.clip_top));
        write_reg(cckb_pkg::CFG_CLIP_RIGHT, 24'(c.clip_right));
        write_reg(cckb_pkg::CFG_CLIP_BOTTOM, 24'(c.clip_bottom));
        write_reg(cckb_pkg::CFG_DEST_PITCH, 24'(c.dest_pitch));
        write_reg(cckb_pkg::CFG_DEST_BASE, c.dest_base);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_idle_pixel();
        send_beat(mk_pixel(8'hFF));
    endtask

    task automatic test_keyed_corner_clip();
        send_beat(mk_start(-2, -1, 5, 7, 4, 3, 1'b1));
        send_beat(mk_pixel(8'h00));
        send_beat(mk_pixel(8'hFF));
        send_beat(mk_pixel(8'h00));
        send_beat(mk_pixel(8'h80));
    endtask

    task automatic test_rejected_rects();
        send_beat(mk_start(2047, 0, 1, 1, 4, 4, 1'b0));
        send_beat(mk_start(-2048, -2048, 0, 0, 0, 0, 1'b1));
        send_beat(mk_start(0, -20, 3, 3, 5, 10, 1'b0));
    endtask

    task automatic test_empty_run();
        send_beat(mk_start(10, 10, 2, 2, 0, 5, 1'b1));
        send_beat(mk_pixel(8'h55));
    endtask

    task automatic test_abandon_and_edges();
        send_beat(mk_start(-1000, -1000, 2047, 2047, 2047, 2047, 1'b0));
        repeat (3) send_beat(mk_pixel(rand_pixel()));
        send_beat(mk_start(318, 239, 0, 0, 5, 3, 1'b0));
        send_beat(mk_pixel(8'h00));
        send_beat(mk_pixel(8'h7F));
    endtask

    task automatic test_inverted_window();
        load_regs('{11'd5, 11'd0, 11'd3, 11'd240, 13'd320, 24'd0});
        send_beat(mk_start(0, 0, 0, 0, 10, 10, 1'b1));
        send_beat(mk_pixel(8'h01));
    endtask

    // zero pitch keeps every row on the same address, base near the top wraps
    task automatic test_address_wrap();
        load_regs('{11'd0, 11'd0, 11'd2047, 11'd2047, 13'd0, 24'hFFFFFF});
        send_beat(mk_start(1, 3, 0, 0, 2, 2, 1'b1));
        send_beat(mk_pixel(8'hFF));
        send_beat(mk_pixel(8'h00));
        send_beat(mk_pixel(8'h01));
        send_beat(mk_pixel(8'h80));
    endtask

    task automatic test_random_traffic();
        int    budgets[7] = '{400, 50, 50, 360, 360, 360, 360};
        int    stop_at;
        int    run_len;
        for (int p = 0; p < 7; p++) begin
            load_regs(pick_regs(p));
            stop_at = beats_sent + budgets[p];
            while (beats_sent < stop_at) begin
                idle_off = ($urandom_range(0, 7) == 0);
                if ($urandom_range(0, 9) == 0) send_beat(mk_pixel(rand_pixel()));
                send_beat(make_start());
                if (latest_answer.run_width != 0 && latest_answer.run_height != 0) begin
                    run_len = int'(latest_answer.run_width) * int'(latest_answer.run_height);
                    // long runs, and now and then a shorter one, get cut short and abandoned by the next start
                    if (run_len > 64 || $urandom_range(0, 11) == 0) begin
                        run_len = $urandom_range(1, (run_len > 64) ? 64 : run_len);
                    end
                    repeat (run_len) send_beat(mk_pixel(rand_pixel()));
                end
            end
        end
        idle_off = 1'b0;
    endtask

    initial begin
        i_out_stall = 1'b0;
        forever begin
            out_hold = pick_wait();
            @(negedge i_clk);
            if (out_hold != 0) begin
                i_out_stall = 1'b1;
                repeat (out_hold) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (answers_due.size() == 0) begin
                flag_mismatch("result beat with nothing expected");
            end else begin
                due_beat = answers_due.pop_front();
                check_field("is_status", 24'(due_beat.is_status), 24'(o_is_status));
                check_field("status", 24'(due_beat.status), 24'(o_status));
                check_field("clipped_src_x", 24'(due_beat.clipped_src_x),
                            24'(o_clipped_src_x));
                check_field("clipped_src_y", 24'(due_beat.clipped_src_y),
                            24'(o_clipped_src_y));
                check_field("run_width", 24'(due_beat.run_width), 24'(o_run_width));
                check_field("run_height", 24'(due_beat.run_height), 24'(o_run_height));
                check_field("write_enable", 24'(due_beat.write_enable), 24'(o_write_enable));
                check_field("write_address", due_beat.write_address, o_write_address);
                check_field("write_pixel", 24'(due_beat.write_pixel), 24'(o_write_pixel));
                check_field("last_pixel", 24'(due_beat.last_pixel), 24'(o_last_pixel));
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_opcode      = cckb_pkg::OP_START;
        i_dest_x      = '0;
        i_dest_y      = '0;
        i_src_x       = '0;
        i_src_y       = '0;
        i_rect_width  = '0;
        i_rect_height = '0;
        i_use_key     = 1'b0;
        i_pixel       = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_pixel();
        test_keyed_corner_clip();
        test_rejected_rects();
        test_empty_run();
        test_abandon_and_edges();
        test_inverted_window();
        test_address_wrap();
        test_random_traffic();

        settle();
        repeat (8) @(posedge i_clk);
        if (answers_due.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", answers_due.size()));
        end
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cckb_pkg.sv
hw/rtl/cckb_front.sv
hw/rtl/cckb_queue.sv
hw/rtl/cckb_back.sv
hw/rtl/clipped_color_key_blitter_core.sv
hw/rtl/cckb_checker.sv
sim/testbench.sv
